FILE: sv/echr_pkg.sv
// ----------------------------------------------------------------------------
// echr_pkg
// Item types and codes shared by the epoch credits history ring.
// ----------------------------------------------------------------------------
package echr_pkg;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [63:0] ALL_ONES = '1;

  typedef struct packed {
    logic        opcode;
    logic [63:0] epoch;
    logic [63:0] credit_amount;
    logic [6:0]  position;
  } echr_in_t;

  typedef struct packed {
    logic [63:0] entry_epoch;
    logic [63:0] entry_credits;
    logic [63:0] entry_prev_credits;
    logic        entry_is_marker;
    logic        entry_valid;
    logic [6:0]  entry_count;
  } echr_out_t;

  // one stored history entry, as it sits in a ring word
  typedef struct packed {
    logic [63:0] epoch;
    logic [63:0] credits;
    logic [63:0] start_credits;
  } echr_entry_t;

endpackage

FILE: sv/echr_ram.sv
// ----------------------------------------------------------------------------
// echr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module echr_ram #(
  parameter int WIDTH = 192,
  parameter int DEPTH = 65
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/epoch_credits_history_ring_top.sv
// ----------------------------------------------------------------------------
// epoch_credits_history_ring_top
// Oldest-first ring of per-epoch credit entries with saturating adds,
// a one-time migration marker and positional reads.
// ----------------------------------------------------------------------------
// flow: each item goes through dispatch, a ring read and a done state that waits for
//   a free output; an add into an empty store skips the read, an add that finds a
//   marker tail also reads the entry before it, and no new item is taken until idle;
//   one ring read port serves the tail read and the dependent read of that entry
// reset: pointers, count and marker tracking clear, migration epoch goes to
//   all ones; ring contents are not cleared, only stored entries ever reach a result
module epoch_credits_history_ring_top
  import echr_pkg::*;
#(
  parameter int HISTORY_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  echr_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output echr_out_t   out_data,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata
);

  localparam int CAP = HISTORY_DEPTH + 1;
  localparam int AW  = $clog2(CAP);
  localparam int CW  = $clog2(CAP + 1);
  localparam int PW  = (CW > 7) ? CW : 7;
  localparam int EW  = $bits(echr_entry_t);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DISP  = 3'd1;
  localparam logic [2:0] ST_ADD1  = 3'd2;
  localparam logic [2:0] ST_ADDMK = 3'd3;
  localparam logic [2:0] ST_RDATA = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  typedef struct packed {
    logic [AW-1:0] head;
    logic [CW-1:0] count;
    logic          mkp;    // some stored entry is a marker
    logic [AW-1:0] mkpos;  // position of the youngest marker
  } ring_t;

  typedef struct packed {
    ring_t         r;
    logic [AW-1:0] slot;
  } push_t;

  // --------------------------------------------------------------------------
  // helpers
  // --------------------------------------------------------------------------
  function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? ALL_ONES : s[63:0];
  endfunction

  function automatic logic is_mk(echr_entry_t e);
    return (e.epoch == ALL_ONES) && (e.credits == ALL_ONES) &&
           (e.start_credits == ALL_ONES);
  endfunction

  function automatic logic [AW-1:0] slot_of(logic [AW-1:0] h, logic [CW-1:0] p);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(p);
    if (s >= (CW+1)'(CAP)) begin
      s = s - (CW+1)'(CAP);
    end
    return s[AW-1:0];
  endfunction

  function automatic ring_t pop_head(ring_t r);
    ring_t q;
    q = r;
    if (r.count != '0) begin
      if (r.mkp) begin
        if (r.mkpos == '0) begin
          q.mkp = 1'b0;
        end else begin
          q.mkpos = r.mkpos - AW'(1);
        end
      end
      q.head  = (r.head == AW'(CAP - 1)) ? '0 : r.head + AW'(1);
      q.count = r.count - CW'(1);
    end
    return q;
  endfunction

  function automatic push_t push_tail(ring_t r, logic mk);
    push_t p;
    p.r = r;
    if (r.count >= CW'(CAP)) begin
      p.r = pop_head(p.r);
    end
    p.slot    = slot_of(p.r.head, p.r.count);
    p.r.count = p.r.count + CW'(1);
    if (mk) begin
      p.r.mkp   = 1'b1;
      p.r.mkpos = AW'(p.r.count - CW'(1));
    end
    return p;
  endfunction

  function automatic ring_t trim(ring_t r);
    ring_t q;
    q = r;
    if (r.count > CW'(HISTORY_DEPTH)) begin
      q = pop_head(r);
    end
    return q;
  endfunction

  function automatic echr_out_t make_res(echr_entry_t e, logic [CW-1:0] cnt);
    echr_out_t o;
    o.entry_epoch        = e.epoch;
    o.entry_credits      = e.credits;
    o.entry_prev_credits = e.start_credits;
    o.entry_is_marker    = is_mk(e);
    o.entry_valid        = 1'b1;
    o.entry_count        = 7'(cnt);
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // state
  // --------------------------------------------------------------------------
  logic [2:0]  state_r, state_nxt;
  ring_t       ring_r, ring_nxt;
  echr_in_t    item_r, item_nxt;
  echr_out_t   res_r, res_nxt;
  echr_out_t   out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        base_zero_r, base_zero_nxt;
  logic [63:0] mig_r;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  echr_entry_t   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;
  echr_entry_t   rd_e;

  assign rd_e = echr_entry_t'(ram_rdata);

  echr_ram #(
    .WIDTH (EW),
    .DEPTH (CAP)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (EW'(ram_wdata)),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    push_t       pt;
    echr_entry_t new_e;
    logic [63:0] base;
    logic [PW-1:0] pos_ext;

    state_nxt     = state_r;
    ring_nxt      = ring_r;
    item_nxt      = item_r;
    res_nxt       = res_r;
    base_zero_nxt = base_zero_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    ram_we        = 1'b0;
    ram_waddr     = ring_r.head;
    ram_wdata     = '0;
    ram_raddr     = ring_r.head;
    pt            = '0;
    new_e         = '0;
    base          = '0;
    pos_ext       = PW'(item_r.position);

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = ST_DISP;
        end
      end

      ST_DISP: begin
        if (item_r.opcode == OP_READ) begin
          res_nxt             = '0;
          res_nxt.entry_count = 7'(ring_r.count);
          res_nxt.entry_valid = pos_ext < PW'(ring_r.count);
          ram_raddr           = slot_of(ring_r.head, pos_ext[CW-1:0]);
          state_nxt           = ST_RDATA;
        end else if (item_r.credit_amount == '0) begin
          // no change, report the tail
          res_nxt             = '0;
          res_nxt.entry_count = 7'(ring_r.count);
          res_nxt.entry_valid = ring_r.count != '0;
          ram_raddr           = slot_of(ring_r.head, ring_r.count - CW'(1));
          state_nxt           = ST_RDATA;
        end else if (item_r.epoch == mig_r && !ring_r.mkp) begin
          // marker goes in first, old tail is fetched as the base
          pt            = push_tail(ring_r, 1'b1);
          ram_we        = 1'b1;
          ram_waddr     = pt.slot;
          ram_wdata     = '{ALL_ONES, ALL_ONES, ALL_ONES};
          ram_raddr     = slot_of(ring_r.head, ring_r.count - CW'(1));
          base_zero_nxt = ring_r.count == '0;
          ring_nxt      = pt.r;
          state_nxt     = ST_ADDMK;
        end else if (ring_r.count == '0) begin
          new_e     = '{item_r.epoch, item_r.credit_amount, 64'd0};
          pt        = push_tail(ring_r, 1'b0);
          ram_we    = 1'b1;
          ram_waddr = pt.slot;
          ram_wdata = new_e;
          ring_nxt  = pt.r;
          res_nxt   = make_res(new_e, pt.r.count);
          state_nxt = ST_DONE;
        end else begin
          ram_raddr = slot_of(ring_r.head, ring_r.count - CW'(1));
          state_nxt = ST_ADD1;
        end
      end

      ST_ADD1: begin
        if (is_mk(rd_e)) begin
          ram_raddr     = slot_of(ring_r.head, ring_r.count - CW'(2));
          base_zero_nxt = ring_r.count < CW'(2);
          state_nxt     = ST_ADDMK;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = slot_of(ring_r.head, ring_r.count - CW'(1));
          if (rd_e.epoch == item_r.epoch) begin
            new_e = '{rd_e.epoch, sat_add(rd_e.credits, item_r.credit_amount),
                      rd_e.start_credits};
          end else begin
            // idle tail is reused, otherwise the total carries forward
            new_e = '{item_r.epoch, sat_add(rd_e.credits, item_r.credit_amount),
                      rd_e.start_credits};
          end
          if (rd_e.epoch == item_r.epoch || rd_e.credits == rd_e.start_credits) begin
            if (is_mk(new_e)) begin
              ring_nxt.mkp   = 1'b1;
              ring_nxt.mkpos = AW'(ring_r.count - CW'(1));
            end
          end else begin
            new_e       = '{item_r.epoch, sat_add(item_r.credit_amount, rd_e.credits),
                            rd_e.credits};
            pt          = push_tail(ring_r, is_mk(new_e));
            ram_waddr   = pt.slot;
            ring_nxt    = trim(pt.r);
          end
          ram_wdata = new_e;
          res_nxt   = make_res(new_e, ring_nxt.count);
          state_nxt = ST_DONE;
        end
      end

      ST_ADDMK: begin
        base      = base_zero_r ? 64'd0 : rd_e.credits;
        new_e     = '{item_r.epoch, sat_add(item_r.credit_amount, base), base};
        pt        = push_tail(ring_r, is_mk(new_e));
        ram_we    = 1'b1;
        ram_waddr = pt.slot;
        ram_wdata = new_e;
        ring_nxt  = trim(pt.r);
        res_nxt   = make_res(new_e, ring_nxt.count);
        state_nxt = ST_DONE;
      end

      ST_RDATA: begin
        if (res_r.entry_valid) begin
          res_nxt = make_res(rd_e, CW'(res_r.entry_count));
          res_nxt.entry_count = res_r.entry_count;
        end
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ring_r      <= '0;
      out_valid_r <= 1'b0;
      base_zero_r <= 1'b0;
      mig_r       <= ALL_ONES;
    end else begin
      state_r     <= state_nxt;
      ring_r      <= ring_nxt;
      out_valid_r <= out_valid_nxt;
      base_zero_r <= base_zero_nxt;
      if (cfg_we) begin
        mig_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  assign in_stall  = state_r != ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    ring_r.count <= CW'(CAP))
    else $error("ring count above capacity");

  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    (AW+1)'(ring_r.head) < (AW+1)'(CAP))
    else $error("head pointer outside ring");

  a_marker_pos: assert property (@(posedge clk) disable iff (!rst_n)
    ring_r.mkp |-> (CW'(ring_r.mkpos) < ring_r.count))
    else $error("marker position beyond stored entries");

  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_DISP || state_r == ST_ADD1 || state_r == ST_ADDMK))
    else $error("ring written outside an add");

  a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && (!out_valid_r || !out_stall)) |=> out_valid_r)
    else $error("finished item not presented");

endmodule
